// ----- hw/rtl/rai_pkg.sv -----
// Shared types and constants for the ray / annulus intersection block.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none
package rai_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int MIN_DISTANCE = 66;
	localparam int COORD_W      = 32;
	localparam int NORMAL_W     = 18;
	localparam int RAD_W        = 63;
	localparam int T_BITS       = 31;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;

	// Product and dot-product widths; magnitudes of the sums of three products.
	localparam int PD_W   = COORD_W + NORMAL_W;
	localparam int PN_W   = COORD_W + 1 + NORMAL_W;
	localparam int DEN_W  = PD_W;
	localparam int NUM_W  = PN_W;
	localparam int REM_W  = NUM_W + FRAC_BITS;
	localparam int SH_W   = DEN_W + T_BITS;
	localparam int PROD_W = 2 * COORD_W;
	localparam int REL_W  = PROD_W + 2;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [T_BITS-1:0] T_MAX  = {T_BITS{1'b1}};
	localparam logic [RAD_W-1:0]  SQ_MAX = {RAD_W{1'b1}};

	localparam logic [1:0] ST_HIT      = 2'd0;
	localparam logic [1:0] ST_PARALLEL = 2'd1;
	localparam logic [1:0] ST_BEHIND   = 2'd2;
	localparam logic [1:0] ST_OUTSIDE  = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INNER    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OUTER    = 3'd7;

	typedef struct packed {
		logic [2:0][COORD_W-1:0]  center;
		logic [2:0][NORMAL_W-1:0] normal;
		logic [RAD_W-1:0]         inner;
		logic [RAD_W-1:0]         outer;
	} rai_cfg_t;

	// One classified ray as it sits in the queue.
	typedef struct packed {
		logic [1:0]              st;
		logic [2:0][COORD_W-1:0] o;
		logic [2:0][COORD_W-1:0] d;
		logic [NUM_W-1:0]        num;
		logic [DEN_W-1:0]        den;
	} q_entry_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ray_annulus_intersect.sv -----
// Top level of the ray / annulus intersection block: ring registers, front end,
// queue and back end. Depends on rai_pkg, rai_front, rai_queue and rai_back.
//
//   channel  handshake                direction  payload
//   cfg      cfg_valid / cfg_ready    in         cfg_index, cfg_data
//   ray      in_valid / in_stall      in         origin_x/y/z, dir_x/y/z
//   result   out_valid / out_stall    out        hit, distance, status
//
// One ray per cycle sustained while neither in_stall nor out_stall is raised. The
// request passes 39 registers, the first loaded at the taking edge: two front
// stages, the queue, an entry register and 31 one-bit division stages for t, then
// the t*D product, the offset, the squares and the ring test result.
// Reset clears the ring to center 0, normal (0,0,1.0) and zero radii.
// A stall on the result side holds the back end; the four-entry queue keeps
// taking requests until it fills, then in_stall rises.
`default_nettype none
module ray_annulus_intersect import rai_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [COORD_W-1:0]    origin_x,
	input  wire logic [COORD_W-1:0]    origin_y,
	input  wire logic [COORD_W-1:0]    origin_z,
	input  wire logic [COORD_W-1:0]    dir_x,
	input  wire logic [COORD_W-1:0]    dir_y,
	input  wire logic [COORD_W-1:0]    dir_z,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       hit,
	output logic [T_BITS-1:0]          distance,
	output logic [1:0]                 status
);

	rai_cfg_t cfg_q;
	logic     q_full, q_nonempty, q_push, q_pop;
	q_entry_t q_push_data, q_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center <= '0;
			cfg_q.normal <= {NORMAL_W'(1 << FRAC_BITS), {NORMAL_W{1'b0}}, {NORMAL_W{1'b0}}};
			cfg_q.inner  <= '0;
			cfg_q.outer  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X: cfg_q.center[0] <= cfg_data[COORD_W-1:0];
				REG_CENTER_Y: cfg_q.center[1] <= cfg_data[COORD_W-1:0];
				REG_CENTER_Z: cfg_q.center[2] <= cfg_data[COORD_W-1:0];
				REG_NORMAL_X: cfg_q.normal[0] <= cfg_data[NORMAL_W-1:0];
				REG_NORMAL_Y: cfg_q.normal[1] <= cfg_data[NORMAL_W-1:0];
				REG_NORMAL_Z: cfg_q.normal[2] <= cfg_data[NORMAL_W-1:0];
				REG_INNER:    cfg_q.inner     <= cfg_data[RAD_W-1:0];
				REG_OUTER:    cfg_q.outer     <= cfg_data[RAD_W-1:0];
				default:      cfg_q           <= cfg_q;
			endcase
		end
	end

	rai_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.origin_x  (origin_x),
		.origin_y  (origin_y),
		.origin_z  (origin_z),
		.dir_x     (dir_x),
		.dir_y     (dir_y),
		.dir_z     (dir_z),
		.q_full    (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	rai_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_push_data),
		.pop       (q_pop),
		.full      (q_full),
		.nonempty  (q_nonempty),
		.head      (q_head)
	);

	rai_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.nonempty  (q_nonempty),
		.head      (q_head),
		.pop       (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.hit       (hit),
		.distance  (distance),
		.status    (status)
	);

endmodule
`default_nettype wire

// ----- hw/rtl/rai_front.sv -----
// Front end: accepts rays, forms N.D and N.(C-O) and classifies each ray.
// Depends on rai_pkg; feeds rai_queue.
`default_nettype none
module rai_front import rai_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire rai_cfg_t           cfg,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [COORD_W-1:0] origin_x,
	input  wire logic [COORD_W-1:0] origin_y,
	input  wire logic [COORD_W-1:0] origin_z,
	input  wire logic [COORD_W-1:0] dir_x,
	input  wire logic [COORD_W-1:0] dir_y,
	input  wire logic [COORD_W-1:0] dir_z,
	input  wire logic               q_full,
	output logic                    push,
	output q_entry_t                push_data
);

	logic                    go;
	logic [2:0][COORD_W-1:0] o_in, d_in;
	logic [2:0][PD_W-1:0]    pd_c;
	logic [2:0][PN_W-1:0]    pn_c;

	logic                    v_s1;
	logic [2:0][COORD_W-1:0] o_s1, d_s1;
	logic [2:0][PD_W-1:0]    pd_s1;
	logic [2:0][PN_W-1:0]    pn_s1;

	logic                    v_s2;
	q_entry_t                e_s2, e_c;

	assign go       = !q_full;
	assign in_stall = !go;
	assign push      = v_s2 && go;
	assign push_data = e_s2;

	assign o_in = {origin_z, origin_y, origin_x};
	assign d_in = {dir_z, dir_y, dir_x};

	always_comb begin
		logic signed [COORD_W:0] diff;
		for (int i = 0; i < 3; i++) begin
			diff    = $signed({cfg.center[i][COORD_W-1], cfg.center[i]})
			        - $signed({o_in[i][COORD_W-1], o_in[i]});
			pd_c[i] = PD_W'($signed(cfg.normal[i]) * $signed(d_in[i]));
			pn_c[i] = PN_W'($signed(cfg.normal[i]) * diff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (go) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			o_s1  <= o_in;
			d_s1  <= d_in;
			pd_s1 <= pd_c;
			pn_s1 <= pn_c;
			e_s2  <= e_c;
		end
	end

	// Sum the products, fold the sign of N.D into N.(C-O) and classify.
	always_comb begin
		logic signed [PD_W+1:0] den;
		logic signed [PN_W+1:0] num;
		den = '0;
		num = '0;
		for (int i = 0; i < 3; i++) begin
			den = den + (PD_W+2)'($signed(pd_s1[i]));
			num = num + (PN_W+2)'($signed(pn_s1[i]));
		end
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		e_c.o   = o_s1;
		e_c.d   = d_s1;
		e_c.den = den[DEN_W-1:0];
		e_c.num = num[NUM_W-1:0];
		if (den == 0) begin
			e_c.st = ST_PARALLEL;
		end else if (num < 0) begin
			e_c.st = ST_BEHIND;
		end else begin
			e_c.st = ST_HIT;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rai_queue.sv -----
// Short FIFO between the front end and the back end.
// Depends on rai_pkg for the entry type and depth.
`default_nettype none
module rai_queue import rai_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t push_data,
	input  wire logic     pop,
	output logic          full,
	output logic          nonempty,
	output q_entry_t      head
);

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   count_q;

	assign full     = (count_q == (QPTR_W+1)'(QDEPTH));
	assign nonempty = (count_q != '0);
	assign head     = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/rai_back.sv -----
// Back end: bit-per-stage division for t, crossing point, squared distance
// and the ring test, ending in the output register. Depends on rai_pkg.
`default_nettype none
module rai_back import rai_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire rai_cfg_t    cfg,
	input  wire logic        nonempty,
	input  wire q_entry_t    head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             hit,
	output logic [T_BITS-1:0] distance,
	output logic [1:0]       status
);

	typedef struct packed {
		logic [1:0]              st;
		logic                    sat;
		logic [2:0][COORD_W-1:0] o;
		logic [2:0][COORD_W-1:0] d;
		logic [DEN_W-1:0]        den;
		logic [REM_W-1:0]        rem;
		logic [T_BITS-1:0]       q;
	} div_t;

	logic move;
	logic div_v_s [T_BITS+1];
	div_t div_s   [T_BITS+1];
	div_t div_c   [T_BITS+1];

	logic                    v_s1;
	logic [1:0]              st_s1;
	logic [T_BITS-1:0]       t_s1;
	logic [2:0][COORD_W-1:0] o_s1;
	logic [2:0][PROD_W-1:0]  prod_s1;

	logic                    v_s2;
	logic [1:0]              st_s2;
	logic [T_BITS-1:0]       t_s2;
	logic                    ovf_s2;
	logic [2:0][31:0]        m_s2;

	logic                    v_s3;
	logic [1:0]              st_s3;
	logic [T_BITS-1:0]       t_s3;
	logic                    ovf_s3;
	logic [2:0][63:0]        sq_s3;

	logic                    out_valid_q;
	logic [1:0]              status_q;
	logic [T_BITS-1:0]       t_q;

	logic [T_BITS-1:0]       t_c;
	logic [2:0][PROD_W-1:0]  prod_c;
	logic                    ovf_c;
	logic [2:0][31:0]        m_c;
	logic [2:0][63:0]        sq_c;
	logic [1:0]              status_c;

	// The whole back end advances together unless a result is held by the sink.
	assign move = !(out_valid_q && out_stall);
	assign pop  = move && nonempty;

	// Stage 0 takes the queue head; t saturates when the quotient needs 2^15 or more.
	always_comb begin
		div_c[0].st  = head.st;
		div_c[0].o   = head.o;
		div_c[0].d   = head.d;
		div_c[0].den = head.den;
		div_c[0].rem = REM_W'(head.num) << FRAC_BITS;
		div_c[0].q   = '0;
		div_c[0].sat = (SH_W'(head.num) >= (SH_W'(head.den) << (T_BITS - FRAC_BITS)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_v_s[0] <= 1'b0;
		end else if (move) begin
			div_v_s[0] <= nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			div_s[0] <= div_c[0];
		end
	end

	for (genvar j = 0; j < T_BITS; j++) begin : g_div
		localparam int K = T_BITS - 1 - j;

		always_comb begin
			logic [SH_W-1:0] sh;
			div_c[j+1] = div_s[j];
			sh = SH_W'(div_s[j].den) << K;
			if (SH_W'(div_s[j].rem) >= sh) begin
				div_c[j+1].rem  = div_s[j].rem - sh[REM_W-1:0];
				div_c[j+1].q[K] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[j+1] <= 1'b0;
			end else if (move) begin
				div_v_s[j+1] <= div_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (move) begin
				div_s[j+1] <= div_c[j+1];
			end
		end
	end

	// t times each direction component.
	always_comb begin
		t_c = div_s[T_BITS].sat ? T_MAX : div_s[T_BITS].q;
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = PROD_W'($signed({1'b0, t_c}) * $signed(div_s[T_BITS].d[i]));
		end
	end

	// Offset from the center, magnitude truncated to the coordinate format.
	always_comb begin
		logic signed [COORD_W:0] diff;
		logic signed [REL_W-1:0] rel;
		logic        [REL_W-1:0] mag;
		ovf_c = 1'b0;
		for (int i = 0; i < 3; i++) begin
			diff   = $signed({cfg.center[i][COORD_W-1], cfg.center[i]})
			       - $signed({o_s1[i][COORD_W-1], o_s1[i]});
			rel    = (REL_W'(diff) <<< FRAC_BITS) - REL_W'($signed(prod_s1[i]));
			mag    = rel[REL_W-1] ? REL_W'(-rel) : REL_W'(rel);
			ovf_c  = ovf_c | (|mag[REL_W-1:FRAC_BITS+32]);
			m_c[i] = mag[FRAC_BITS+31:FRAC_BITS];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_c[i] = 64'(m_s2[i]) * 64'(m_s2[i]);
		end
	end

	always_comb begin
		logic [65:0]      sum;
		logic [RAD_W-1:0] dist2;
		sum   = 66'(sq_s3[0]) + 66'(sq_s3[1]) + 66'(sq_s3[2]);
		dist2 = (ovf_s3 || sum > 66'(SQ_MAX)) ? SQ_MAX : sum[RAD_W-1:0];
		if (st_s3 != ST_HIT) begin
			status_c = st_s3;
		end else if (t_s3 < T_BITS'(MIN_DISTANCE)) begin
			status_c = ST_BEHIND;
		end else if (dist2 > cfg.outer || dist2 < cfg.inner) begin
			status_c = ST_OUTSIDE;
		end else begin
			status_c = ST_HIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (move) begin
			v_s1        <= div_v_s[T_BITS];
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			st_s1    <= div_s[T_BITS].st;
			t_s1     <= t_c;
			o_s1     <= div_s[T_BITS].o;
			prod_s1  <= prod_c;
			st_s2    <= st_s1;
			t_s2     <= t_s1;
			ovf_s2   <= ovf_c;
			m_s2     <= m_c;
			st_s3    <= st_s2;
			t_s3     <= t_s2;
			ovf_s3   <= ovf_s2;
			sq_s3    <= sq_c;
			status_q <= status_c;
			t_q      <= t_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign hit       = (status_q == ST_HIT);
	assign distance  = (status_q == ST_HIT) ? t_q : '0;

endmodule
`default_nettype wire

// ----- dv/tb_ray_annulus_intersect.sv -----
// Self-checking testbench for ray_annulus_intersect: directed rays, then random rays
// under several ring settings, checked against listed results or an in-bench intersection predictor.
// Depends on rai_pkg and the ray_annulus_intersect RTL only.
`default_nettype none
module tb_ray_annulus_intersect;
	import rai_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic             hit;
		logic [T_BITS-1:0] dist_val;
		logic [1:0]        st;
	} ring_res_t;

	typedef struct {
		logic [2:0][COORD_W-1:0] o;
		logic [2:0][COORD_W-1:0] d;
		bit                      typed;
		ring_res_t               res;
	} ray_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [COORD_W-1:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic [COORD_W-1:0] dir_x = '0, dir_y = '0, dir_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic hit;
	logic [T_BITS-1:0] distance;
	logic [1:0] status;

	ray_annulus_intersect u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.hit(hit), .distance(distance), .status(status)
	);

	always #5 clk = ~clk;

	// Ring mirror used by the predictor.
	logic [2:0][COORD_W-1:0]  mir_center;
	logic [2:0][NORMAL_W-1:0] mir_normal;
	logic [RAD_W-1:0]         ring_inner, ring_outer;

	ring_res_t pending_q[$];
	int errors = 0;
	int cycles = 0;
	int results_seen = 0;
	int status_count[4];
	int send_idle_pct = 0, recv_idle_pct = 0;
	bit hold_req = 0;
	logic ray_taken = 1'b0, cfg_taken = 1'b0;

	always @(posedge clk) begin
		ray_taken <= in_valid && !in_stall;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("Timeout at %0t with %0d results outstanding", $time, pending_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic ring_res_t intersect_ring(logic [2:0][COORD_W-1:0] o,
			logic [2:0][COORD_W-1:0] d);
		ring_res_t r;
		logic signed [95:0] num, den, cs, os, ds, ns, rel, ts;
		logic [95:0] q, t, mag, acc;
		bit sat;
		r.hit = 0;
		r.dist_val = '0;
		num = 0;
		den = 0;
		for (int i = 0; i < 3; i++) begin
			cs = $signed(mir_center[i]);
			os = $signed(o[i]);
			ds = $signed(d[i]);
			ns = $signed(mir_normal[i]);
			den += ns * ds;
			num += ns * (cs - os);
		end
		if (den == 0) begin
			r.st = ST_PARALLEL;
			return r;
		end
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num < 0) begin
			r.st = ST_BEHIND;
			return r;
		end
		q = num / den;
		if (q > (T_MAX >> FRAC_BITS))
			t = T_MAX;
		else
			t = (num <<< FRAC_BITS) / den;
		if (t < MIN_DISTANCE) begin
			r.st = ST_BEHIND;
			return r;
		end
		ts = t;
		acc = 0;
		sat = 0;
		for (int i = 0; i < 3; i++) begin
			cs = $signed(mir_center[i]);
			os = $signed(o[i]);
			ds = $signed(d[i]);
			rel = (cs - os) * 96'sd65536 - ts * ds;
			mag = (rel < 0) ? -rel : rel;
			mag = mag >> FRAC_BITS;
			if (mag > 96'hFFFF_FFFF)
				sat = 1;
			else
				acc += mag * mag;
		end
		if (sat || acc > SQ_MAX)
			acc = SQ_MAX;
		if (acc > ring_outer || acc < ring_inner) begin
			r.st = ST_OUTSIDE;
			return r;
		end
		r.hit = 1;
		r.dist_val = t[T_BITS-1:0];
		r.st = ST_HIT;
		return r;
	endfunction

	// Result checker.
	always @(posedge clk) begin
		ring_res_t e;
		if (out_valid && !out_stall) begin
			results_seen++;
			status_count[status]++;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result hit=%0b distance=%0d status=%0d",
					$time, hit, distance, status);
			end else begin
				e = pending_q.pop_front();
				if (hit !== e.hit) begin
					errors++;
					$display("%0t: hit expected %0b actual %0b", $time, e.hit, hit);
				end
				if (distance !== e.dist_val) begin
					errors++;
					$display("%0t: distance expected %0d actual %0d", $time, e.dist_val,
						distance);
				end
				if (status !== e.st) begin
					errors++;
					$display("%0t: status expected %0d actual %0d", $time, e.st, status);
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CENTER_X, REG_CENTER_Y, REG_CENTER_Z: begin
				mir_center[idx] = val[COORD_W-1:0];
			end
			REG_NORMAL_X, REG_NORMAL_Y, REG_NORMAL_Z: begin
				mir_normal[idx - REG_NORMAL_X] = val[NORMAL_W-1:0];
			end
			REG_INNER: ring_inner = val[RAD_W-1:0];
			default: ring_outer = val[RAD_W-1:0];
		endcase
		@(negedge clk);
	endtask

	task automatic set_ring(logic [2:0][COORD_W-1:0] c, logic [2:0][NORMAL_W-1:0] n,
			logic [RAD_W-1:0] inner, logic [RAD_W-1:0] outer);
		for (int i = 0; i < 3; i++) begin
			write_reg(REG_CENTER_X + CFG_IDX_W'(i), {{32{c[i][COORD_W-1]}}, c[i]});
			write_reg(REG_NORMAL_X + CFG_IDX_W'(i), {{46{n[i][NORMAL_W-1]}}, n[i]});
		end
		write_reg(REG_INNER, {1'b0, inner});
		write_reg(REG_OUTER, {1'b0, outer});
	endtask

	// Sender is at a falling edge on entry and on return.
	task automatic send_ray(logic [2:0][COORD_W-1:0] o, logic [2:0][COORD_W-1:0] d,
			bit typed, ring_res_t typed_res);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		{origin_z, origin_y, origin_x} <= o;
		{dir_z, dir_y, dir_x} <= d;
		do @(negedge clk); while (!ray_taken);
		pending_q.push_back(typed ? typed_res : intersect_ring(o, d));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Mostly rays aimed through a point near the ring center; some pure noise.
	task automatic make_ray(output logic [2:0][COORD_W-1:0] o,
			output logic [2:0][COORD_W-1:0] d, input int reach);
		int tsteps;
		logic signed [COORD_W-1:0] dv, pv;
		if ($urandom_range(99) < 25) begin
			for (int i = 0; i < 3; i++) begin
				o[i] = $urandom;
				d[i] = $urandom;
			end
		end else begin
			tsteps = $urandom_range(64, 1);
			for (int i = 0; i < 3; i++) begin
				dv = $signed($urandom_range(1 << 18, 0)) - (1 << 17);
				pv = $signed(mir_center[i]) + $signed($urandom_range(2 * reach, 0)) - reach;
				if ($urandom_range(9) == 0)
					dv = 0;
				d[i] = dv;
				o[i] = pv - tsteps * dv;
			end
		end
	endtask

	localparam logic [COORD_W-1:0] ONE = 32'h0001_0000;
	localparam logic [COORD_W-1:0] NEG_ONE = 32'hFFFF_0000;
	localparam logic [COORD_W-1:0] CMAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] CMIN = 32'h8000_0000;

	ray_row_t ray_table[$];

	task automatic add_row(logic [2:0][COORD_W-1:0] o, logic [2:0][COORD_W-1:0] d,
			bit typed, logic h, logic [T_BITS-1:0] dist_val, logic [1:0] st);
		ray_row_t row;
		row.o = o;
		row.d = d;
		row.typed = typed;
		row.res.hit = h;
		row.res.dist_val = dist_val;
		row.res.st = st;
		ray_table.push_back(row);
	endtask

	initial begin
		logic [2:0][COORD_W-1:0] o, d;
		logic [2:0][COORD_W-1:0] c;
		logic [2:0][NORMAL_W-1:0] n;
		logic [RAD_W-1:0] r_in, r_out;
		ring_res_t none;
		int reach;
		none = '{0, '0, ST_HIT};

		mir_center = '0;
		mir_normal = '0;
		mir_normal[2] = 18'h1_0000;
		ring_inner = '0;
		ring_outer = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed rays against the reset ring: center 0, normal +z, zero radii.
		add_row({2 * ONE, 32'd0, 32'd0}, {NEG_ONE, 32'd0, 32'd0}, 1, 1, 31'd131072, ST_HIT);
		add_row({2 * ONE, 32'd0, 32'd0}, {32'd0, 32'd0, ONE}, 1, 0, 0, ST_PARALLEL);
		add_row({2 * ONE, 32'd0, 32'd0}, {ONE, 32'd0, 32'd0}, 1, 0, 0, ST_BEHIND);
		add_row({32'd1, 32'd0, 32'd0}, {NEG_ONE, 32'd0, 32'd0}, 1, 0, 0, ST_BEHIND);
		add_row({2 * ONE, 32'd0, ONE}, {NEG_ONE, 32'd0, 32'd0}, 1, 0, 0, ST_OUTSIDE);
		add_row({32'd0, 32'd0, 32'd0}, {32'd0, 32'd0, 32'd0}, 1, 0, 0, ST_PARALLEL);
		add_row({CMAX, 32'd0, 32'd0}, {32'hFFFF_FFFF, 32'd0, 32'd0}, 0, 0, 0, 0);
		add_row({CMAX, 32'd0, 32'd0}, {CMIN, 32'd0, 32'd0}, 0, 0, 0, 0);
		add_row({CMIN, CMIN, CMIN}, {CMAX, CMAX, CMAX}, 0, 0, 0, 0);
		add_row({CMAX, CMAX, CMAX}, {CMIN, CMIN, CMIN}, 0, 0, 0, 0);
		add_row({CMAX, CMIN, CMAX}, {32'hFFFF_FFFF, CMAX, CMIN}, 0, 0, 0, 0);
		add_row({32'd66, 32'd0, 32'd0}, {NEG_ONE, 32'd0, 32'd0}, 0, 0, 0, 0);
		add_row({32'd65, 32'd0, 32'd0}, {NEG_ONE, 32'd0, 32'd0}, 0, 0, 0, 0);
		add_row({ONE, 32'h7FFF, ONE}, {32'hFFFF_FFFF, 32'd0, 32'd0}, 0, 0, 0, 0);
		foreach (ray_table[i])
			send_ray(ray_table[i].o, ray_table[i].d, ray_table[i].typed, ray_table[i].res);
		drain();

		// Random phases, each under a new ring setting.
		for (int ph = 0; ph < 8; ph++) begin
			reach = 1 << $urandom_range(22, 14);
			for (int i = 0; i < 3; i++) begin
				c[i] = $signed($urandom_range(1 << 25, 0)) - (1 << 24);
				n[i] = 0;
			end
			n[ph % 3] = (ph & 1) ? -18'sd65536 : 18'sd65536;
			r_in = RAD_W'({$urandom_range(reach >> 17, 0), 32'd0});
			r_in = r_in * (reach >> 16);
			r_out = 63'(reach >> 16) * 63'(reach >> 16) << 33;
			case (ph)
				1: begin
					c = {CMAX, CMIN, CMAX};
					r_in = '0;
					r_out = SQ_MAX;
				end
				3: begin
					n = {-18'sd46341, 18'sd46341, 18'sd0};
					n[0] = NORMAL_W'($urandom);
				end
				4: begin
					{r_in, r_out} = {r_out, r_in};
				end
				5: begin
					c = {CMIN, CMAX, CMIN};
					n = {18'sd65536, -18'sd65536, 18'sd65536};
					r_in = SQ_MAX;
					r_out = SQ_MAX;
				end
				6: begin
					n = {18'($urandom), 18'($urandom), 18'($urandom)};
					r_in = '0;
				end
				default: ;
			endcase
			set_ring(c, n, r_in, r_out);
			if (ph < 3) begin
				send_idle_pct = 7;
				recv_idle_pct = 68;
			end else if (ph < 6) begin
				send_idle_pct = 68;
				recv_idle_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int k = 0; k < 210; k++) begin
				if (ph == 6 && k == 20)
					hold_req = 1;
				make_ray(o, d, reach);
				send_ray(o, d, 0, none);
			end
			drain();
		end

		$display("Checked %0d results: %0d hits, %0d parallel, %0d behind or too near,",
			results_seen, status_count[ST_HIT], status_count[ST_PARALLEL],
			status_count[ST_BEHIND]);
		$display("%0d outside the ring, over nine ring settings.", status_count[ST_OUTSIDE]);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
`default_nettype wire
